/* hw/rtl/roct_pkg.sv */
// Shared codes, types and command/status structs for the recency-ordered count table.
package roct_pkg;

  localparam int ID_W     = 16;
  localparam int CNT_W    = 16;
  localparam int STATUS_W = 3;
  localparam int FUNC_W   = 2;

  localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LIST   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CAP_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_COPY   = 3'd4;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd64;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SR_RD,
    S_SR_CMP,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_RESP,
    S_LS_RD,
    S_LS_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_next;
    logic ptr_inc;
    logic ptr_dec;
    logic found_set;
    logic decide;
    logic shift_wr;
    logic resp_load;
    logic entry_load;
  } cmd_t;

  typedef struct packed {
    logic in_op;
    logic in_list;
    logic kinds_zero;
    logic hit;
    logic at_end;
    logic shift_done;
    logic need_shift;
    logic ptr_zero;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/recency_ordered_count_table_top.sv */
// Top level of the recency-ordered count table.
//
//  channel | direction | handshake             | payload
//  in_     | request   | in_valid / in_stall   | in_func, in_item_id, in_copy_index
//  out_    | result    | out_valid / out_stall | out_status, out_entry_valid, out_id,
//          |           |                       | out_count, out_last
//  cfg_    | write     | cfg_wr_en             | cfg_wr_data (capacity limit)
//
// Add/remove: search from position 0 to a hit or the end, then shift later entries down
// where an entry leaves or moves to the newest end, paced by one registered read a cycle.
// List: reads the held kinds newest first. A waiting result that stays stalled holds it back.
// One request in flight; the result register lets the next request be taken while the
// previous result is still stalled.
// Reset clears the counts and sets the limit to 64; entry memory is not cleared.
module recency_ordered_count_table_top #(
  parameter int MAX_KINDS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [roct_pkg::FUNC_W-1:0]     in_func,
  input  logic [roct_pkg::ID_W-1:0]       in_item_id,
  input  logic [roct_pkg::CNT_W-1:0]      in_copy_index,
  input  logic                            cfg_wr_en,
  input  logic [roct_pkg::CNT_W-1:0]      cfg_wr_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [roct_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_entry_valid,
  output logic [roct_pkg::ID_W-1:0]       out_id,
  output logic [roct_pkg::CNT_W-1:0]      out_count,
  output logic                            out_last
);
  import roct_pkg::*;

  cmd_t cmd;
  sts_t sts;

  roct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  roct_dp #(
    .MAX_KINDS (MAX_KINDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_item_id      (in_item_id),
    .in_copy_index   (in_copy_index),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_valid (out_entry_valid),
    .out_id          (out_id),
    .out_count       (out_count),
    .out_last        (out_last)
  );

endmodule

/* hw/rtl/roct_dp.sv */
// Datapath: entry memory, search/shift pointer, counters, limit register and result register.
module roct_dp #(
  parameter int MAX_KINDS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  roct_pkg::cmd_t                  cmd,
  output roct_pkg::sts_t                  sts,
  input  logic [roct_pkg::FUNC_W-1:0]     in_func,
  input  logic [roct_pkg::ID_W-1:0]       in_item_id,
  input  logic [roct_pkg::CNT_W-1:0]      in_copy_index,
  input  logic                            cfg_wr_en,
  input  logic [roct_pkg::CNT_W-1:0]      cfg_wr_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [roct_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_entry_valid,
  output logic [roct_pkg::ID_W-1:0]       out_id,
  output logic [roct_pkg::CNT_W-1:0]      out_count,
  output logic                            out_last
);
  import roct_pkg::*;

  localparam int AW = (MAX_KINDS > 1) ? $clog2(MAX_KINDS) : 1;
  localparam int KW = $clog2(MAX_KINDS + 1);
  localparam logic [KW-1:0] KMAX = KW'(MAX_KINDS);
  localparam logic [KW-1:0] KONE = KW'(1);

  entry_t mem [MAX_KINDS];
  entry_t rdata_r;

  logic [FUNC_W-1:0]   func_r;
  logic [ID_W-1:0]     id_r;
  logic [CNT_W-1:0]    idx_r;
  logic [CNT_W-1:0]    limit_r;
  logic [CNT_W-1:0]    total_r;
  logic [KW-1:0]       kinds_r;
  logic [KW-1:0]       ptr_r;
  logic [KW-1:0]       pos_r;
  logic                found_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [CNT_W-1:0]    res_cnt_r;
  logic [KW-1:0]       wa_r;
  logic                do_write_r;
  logic                kinds_inc_r;
  logic                kinds_dec_r;
  logic                total_inc_r;
  logic                total_dec_r;
  logic                need_shift_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_entry_valid_r;
  logic [ID_W-1:0]     out_id_r;
  logic [CNT_W-1:0]    out_count_r;
  logic                out_last_r;

  logic [KW-1:0]       ptr_p1;
  logic [KW-1:0]       rd_addr;
  logic                wr_en;
  logic [KW-1:0]       wr_addr;
  entry_t              wr_data;
  logic                out_free;
  logic                is_op;

  logic [STATUS_W-1:0] dec_status;
  logic [CNT_W-1:0]    dec_cnt;
  logic [KW-1:0]       dec_wa;
  logic                dec_write;
  logic                dec_kinc;
  logic                dec_kdec;
  logic                dec_tinc;
  logic                dec_tdec;
  logic                dec_shift;

  assign ptr_p1   = ptr_r + KONE;
  assign rd_addr  = cmd.rd_next ? ptr_p1 : ptr_r;
  assign wr_en    = cmd.shift_wr | (cmd.resp_load & do_write_r);
  assign wr_addr  = cmd.shift_wr ? ptr_r : wa_r;
  assign wr_data  = cmd.shift_wr ? rdata_r : entry_t'({id_r, res_cnt_r});
  assign out_free = !out_valid_r || !out_stall;
  assign is_op    = (func_r == FN_ADD) || (func_r == FN_REMOVE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    rdata_r <= mem[rd_addr[AW-1:0]];
  end

  // add / remove outcome from search results
  always_comb begin
    dec_status = ST_OK;
    dec_cnt    = cnt_r;
    dec_wa     = kinds_r;
    dec_write  = 1'b0;
    dec_kinc   = 1'b0;
    dec_kdec   = 1'b0;
    dec_tinc   = 1'b0;
    dec_tdec   = 1'b0;
    dec_shift  = 1'b0;
    if (func_r == FN_ADD) begin
      if (total_r >= limit_r) begin
        dec_status = ST_CAP_FULL;
      end else if (!found_r && (kinds_r == KMAX)) begin
        dec_status = ST_TABLE_FULL;
        dec_cnt    = '0;
      end else begin
        dec_cnt   = cnt_r + CNT_W'(1);
        dec_write = 1'b1;
        dec_tinc  = 1'b1;
        if (found_r) begin
          dec_shift = 1'b1;
          dec_wa    = kinds_r - KONE;
        end else begin
          dec_kinc = 1'b1;
        end
      end
    end else begin
      if (!found_r) begin
        dec_status = ST_ABSENT;
        dec_cnt    = '0;
      end else if (idx_r >= cnt_r) begin
        dec_status = ST_BAD_COPY;
      end else begin
        dec_cnt  = cnt_r - CNT_W'(1);
        dec_tdec = 1'b1;
        dec_wa   = pos_r;
        if (dec_cnt == '0) begin
          dec_shift = 1'b1;
          dec_kdec  = 1'b1;
        end else begin
          dec_write = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r       <= in_func;
      id_r         <= in_item_id;
      idx_r        <= in_copy_index;
      found_r      <= 1'b0;
      cnt_r        <= '0;
      pos_r        <= '0;
      ptr_r        <= (in_func == FN_LIST) ? kinds_r - KONE : '0;
      res_status_r <= ST_OK;
      res_cnt_r    <= '0;
      wa_r         <= '0;
      do_write_r   <= 1'b0;
      kinds_inc_r  <= 1'b0;
      kinds_dec_r  <= 1'b0;
      total_inc_r  <= 1'b0;
      total_dec_r  <= 1'b0;
      need_shift_r <= 1'b0;
    end else if (cmd.decide) begin
      res_status_r <= dec_status;
      res_cnt_r    <= dec_cnt;
      wa_r         <= dec_wa;
      do_write_r   <= dec_write;
      kinds_inc_r  <= dec_kinc;
      kinds_dec_r  <= dec_kdec;
      total_inc_r  <= dec_tinc;
      total_dec_r  <= dec_tdec;
      need_shift_r <= dec_shift;
      ptr_r        <= pos_r;
    end else begin
      if (cmd.found_set) begin
        found_r <= 1'b1;
        pos_r   <= ptr_r;
        cnt_r   <= rdata_r.cnt;
      end
      if (cmd.ptr_inc) begin
        ptr_r <= ptr_p1;
      end else if (cmd.ptr_dec) begin
        ptr_r <= ptr_r - KONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      kinds_r <= '0;
      total_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (cmd.resp_load) begin
        if (kinds_inc_r) begin
          kinds_r <= kinds_r + KONE;
        end else if (kinds_dec_r) begin
          kinds_r <= kinds_r - KONE;
        end
        if (total_inc_r) begin
          total_r <= total_r + CNT_W'(1);
        end else if (total_dec_r) begin
          total_r <= total_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp_load || cmd.entry_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      out_status_r      <= res_status_r;
      out_entry_valid_r <= 1'b0;
      out_id_r          <= is_op ? id_r : '0;
      out_count_r       <= res_cnt_r;
      out_last_r        <= 1'b1;
    end else if (cmd.entry_load) begin
      out_status_r      <= ST_OK;
      out_entry_valid_r <= 1'b1;
      out_id_r          <= rdata_r.id;
      out_count_r       <= rdata_r.cnt;
      out_last_r        <= (ptr_r == '0);
    end
  end

  assign sts.in_op      = (in_func == FN_ADD) || (in_func == FN_REMOVE);
  assign sts.in_list    = (in_func == FN_LIST);
  assign sts.kinds_zero = (kinds_r == '0);
  assign sts.hit        = (rdata_r.id == id_r);
  assign sts.at_end     = (ptr_p1 == kinds_r);
  assign sts.shift_done = (ptr_p1 >= kinds_r);
  assign sts.need_shift = need_shift_r;
  assign sts.ptr_zero   = (ptr_r == '0);
  assign sts.out_free   = out_free;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_valid = out_entry_valid_r;
  assign out_id          = out_id_r;
  assign out_count       = out_count_r;
  assign out_last        = out_last_r;

endmodule

/* hw/rtl/roct_ctrl.sv */
// Controller: state machine that sequences search, shift, commit and listing.
module roct_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  roct_pkg::sts_t sts,
  output roct_pkg::cmd_t cmd
);
  import roct_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_op && !sts.kinds_zero) begin
            state_nxt = S_SR_RD;
          end else if (sts.in_op) begin
            state_nxt = S_DECIDE;
          end else if (sts.in_list && !sts.kinds_zero) begin
            state_nxt = S_LS_RD;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SR_RD: begin
        state_nxt = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (sts.hit) begin
          cmd.found_set = 1'b1;
          state_nxt     = S_DECIDE;
        end else if (sts.at_end) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_SR_RD;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_SH_RD;
      end
      S_SH_RD: begin
        if (!sts.need_shift || sts.shift_done) begin
          state_nxt = S_RESP;
        end else begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.ptr_inc  = 1'b1;
        state_nxt    = S_SH_RD;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_LS_RD: begin
        state_nxt = S_LS_OUT;
      end
      S_LS_OUT: begin
        if (sts.out_free) begin
          cmd.entry_load = 1'b1;
          if (sts.ptr_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.ptr_dec = 1'b1;
            state_nxt   = S_LS_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/roct_checker.sv */
// Port-level checker for the recency-ordered count table, bound to the top level.
module roct_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [roct_pkg::STATUS_W-1:0]   out_status,
  input logic                            out_entry_valid,
  input logic [roct_pkg::ID_W-1:0]       out_id,
  input logic [roct_pkg::CNT_W-1:0]      out_count,
  input logic                            out_last
);
  import roct_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_id)
      && $stable(out_count) && $stable(out_last) && $stable(out_entry_valid))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or busy survived reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken without a working cycle");

  a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_last)
    else $error("add/remove result not marked last");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid |-> out_status == ST_OK)
    else $error("listed entry with error status");

endmodule

bind recency_ordered_count_table_top roct_checker u_roct_checker (.*);
